// ===== src/mwcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mwcs_pkg - shared types and constants for the codeword search
// Request/response structs, status codes and the constant seed-dependency
// table of the linear expansion x[t] = x[t-3]^x[t-8]^x[t-14]^x[t-16].
// ----------------------------------------------------------------------------
package mwcs_pkg;

   localparam int CODE_BITS       = 80;
   localparam int SEED_BITS       = 16;
   localparam int LOW_BITS        = 64;
   localparam int HIGH_BITS       = CODE_BITS - LOW_BITS;
   localparam int ROUND_BITS      = 7;
   localparam int WEIGHT_BITS     = 7;
   localparam int MIN_ROUNDS      = 20;
   localparam int DEF_MAX_ROUNDS  = 80;
   localparam int DEF_TAIL_ROUNDS = 5;
   localparam int GROUP_BITS      = 8;
   localparam int GROUPS          = CODE_BITS / GROUP_BITS;
   localparam int GROUP_CNT_BITS  = $clog2(GROUP_BITS + 1);

   typedef enum logic [1:0] {
      STATUS_FOUND = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [ROUND_BITS-1:0] round_count;
      logic                  clear_tail;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [SEED_BITS-1:0]   win_seed;
      logic [WEIGHT_BITS-1:0] best_weight;
      logic [LOW_BITS-1:0]    rounds_mask_low;
      logic [HIGH_BITS-1:0]   rounds_mask_high;
   } rsp_type;

   typedef logic [SEED_BITS-1:0] dep_row_type;
   typedef dep_row_type [CODE_BITS-1:0] dep_table_type;

   // Row t lists the seed bits whose XOR gives codeword bit t.
   function automatic dep_table_type build_dep();
      dep_table_type d;
      for (int t = 0; t < CODE_BITS; t++) begin
         if (t < SEED_BITS) begin
            d[t] = dep_row_type'(1) << t;
         end else begin
            d[t] = d[t-3] ^ d[t-8] ^ d[t-14] ^ d[t-16];
         end
      end
      return d;
   endfunction

   localparam dep_table_type DEP = build_dep();

   function automatic logic [CODE_BITS-1:0] expand(input logic [SEED_BITS-1:0] seed);
      logic [CODE_BITS-1:0] c;
      for (int t = 0; t < CODE_BITS; t++) begin
         c[t] = ^(seed & DEP[t]);
      end
      return c;
   endfunction

endpackage

// ===== src/min_weight_codeword_search.sv =====
// ----------------------------------------------------------------------------
// min_weight_codeword_search - minimum-weight disturbance vector search
// Sweeps all nonzero 16-bit seeds through one expander and popcount
// pipeline and reports the lightest codeword for the requested round count.
// ----------------------------------------------------------------------------
// A request (start while busy is low) with a round count in range runs a
// sweep of all 65535 nonzero seeds, one seed per cycle through a shared
// expander, a two-stage popcount and a best-so-far compare. The sweep is
// followed by a drain, which waits until no candidate seed is left in the
// pipeline, and by a mask state that forms the rounds mask and raises the
// strobe. busy stays high for the whole sweep. An out-of-range round count
// answers on the next cycle with status 2. The result on rsp_data is marked
// by strobe, high for a single cycle, and cannot be held off: sample it in
// that cycle.
module min_weight_codeword_search
   import mwcs_pkg::*;
#(
   parameter int MAX_ROUNDS  = DEF_MAX_ROUNDS,
   parameter int TAIL_ROUNDS = DEF_TAIL_ROUNDS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    strobe,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_MASK  = 4'b1000
   } state_type;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_INIT = '1;

   state_type state_ff, state_in;

   logic [SEED_BITS-1:0]   seed_ff, seed_in;
   logic [CODE_BITS-1:0]   keep_mask_ff, keep_mask_in;
   logic [CODE_BITS-1:0]   tail_mask_ff, tail_mask_in;

   // stage A: expanded, truncated codeword
   logic                   a_valid_ff, a_valid_in;
   logic [SEED_BITS-1:0]   a_seed_ff, a_seed_in;
   logic [CODE_BITS-1:0]   a_word_ff, a_word_in;
   // stage B: per-byte counts
   logic                      b_valid_ff, b_valid_in;
   logic [SEED_BITS-1:0]      b_seed_ff, b_seed_in;
   logic [GROUP_CNT_BITS-1:0] b_cnt_ff [GROUPS];
   logic [GROUP_CNT_BITS-1:0] b_cnt_in [GROUPS];
   // stage C: total weight
   logic                   c_valid_ff, c_valid_in;
   logic [SEED_BITS-1:0]   c_seed_ff, c_seed_in;
   logic [WEIGHT_BITS-1:0] c_weight_ff, c_weight_in;

   logic                   found_ff, found_in;
   logic [SEED_BITS-1:0]   win_seed_ff, win_seed_in;
   logic [WEIGHT_BITS-1:0] best_weight_ff, best_weight_in;

   logic    strobe_ff, strobe_in;
   rsp_type rsp_ff, rsp_in;

   logic                 accept;
   logic                 in_range;
   logic [SEED_BITS-1:0] exp_seed;
   logic [CODE_BITS-1:0] exp_word;
   logic [CODE_BITS-1:0] kept_word;
   logic                 tail_hit;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = (req_data.round_count >= ROUND_BITS'(MIN_ROUNDS)) &&
                     (req_data.round_count <= ROUND_BITS'(MAX_ROUNDS));

   // one expander serves both the sweep and the final mask readout
   assign exp_seed  = (state_ff == ST_MASK) ? win_seed_ff : seed_ff;
   assign exp_word  = expand(exp_seed);
   assign kept_word = exp_word & keep_mask_ff;
   assign tail_hit  = |(exp_word & tail_mask_ff);

   always_comb begin
      logic [WEIGHT_BITS-1:0] sum;

      state_in       = state_ff;
      seed_in        = seed_ff;
      keep_mask_in   = keep_mask_ff;
      tail_mask_in   = tail_mask_ff;
      found_in       = found_ff;
      win_seed_in    = win_seed_ff;
      best_weight_in = best_weight_ff;
      strobe_in      = 1'b0;
      rsp_in         = rsp_ff;

      a_valid_in = (state_ff == ST_SWEEP) && !tail_hit;
      a_seed_in  = seed_ff;
      a_word_in  = kept_word;

      b_valid_in = a_valid_ff;
      b_seed_in  = a_seed_ff;
      for (int g = 0; g < GROUPS; g++) begin
         b_cnt_in[g] = '0;
         for (int i = 0; i < GROUP_BITS; i++) begin
            b_cnt_in[g] = b_cnt_in[g] + GROUP_CNT_BITS'(a_word_ff[g*GROUP_BITS + i]);
         end
      end

      sum = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum = sum + WEIGHT_BITS'(b_cnt_ff[g]);
      end
      c_valid_in  = b_valid_ff;
      c_seed_in   = b_seed_ff;
      c_weight_in = sum;

      // strict less-than: the earlier seed keeps a tie
      if (c_valid_ff && (c_weight_ff < best_weight_ff)) begin
         found_in       = 1'b1;
         win_seed_in    = c_seed_ff;
         best_weight_in = c_weight_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (in_range) begin
                  state_in       = ST_SWEEP;
                  seed_in        = SEED_BITS'(1);
                  found_in       = 1'b0;
                  win_seed_in    = '0;
                  best_weight_in = WEIGHT_INIT;
                  for (int t = 0; t < CODE_BITS; t++) begin
                     keep_mask_in[t] = ROUND_BITS'(t) < req_data.round_count;
                     tail_mask_in[t] = req_data.clear_tail && keep_mask_in[t] &&
                        ((ROUND_BITS + 1)'(t) + (ROUND_BITS + 1)'(TAIL_ROUNDS) >=
                         {1'b0, req_data.round_count});
                  end
               end else begin
                  strobe_in = 1'b1;
                  rsp_in    = '0;
                  rsp_in.status = STATUS_RANGE;
               end
            end
         end
         ST_SWEEP: begin
            if (seed_ff == '1) begin
               state_in = ST_DRAIN;
            end else begin
               seed_in = seed_ff + SEED_BITS'(1);
            end
         end
         ST_DRAIN: begin
            // only candidates can still update the best entry
            if (!a_valid_ff && !b_valid_ff && !c_valid_ff) begin
               state_in = ST_MASK;
            end
         end
         ST_MASK: begin
            state_in  = ST_IDLE;
            seed_in   = '0;
            strobe_in = 1'b1;
            rsp_in    = '0;
            if (found_ff) begin
               rsp_in.status           = STATUS_FOUND;
               rsp_in.win_seed         = win_seed_ff;
               rsp_in.best_weight      = best_weight_ff;
               rsp_in.rounds_mask_low  = kept_word[LOW_BITS-1:0];
               rsp_in.rounds_mask_high = kept_word[CODE_BITS-1:LOW_BITS];
            end else begin
               rsp_in.status = STATUS_NONE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         seed_ff        <= '0;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         found_ff       <= 1'b0;
         win_seed_ff    <= '0;
         best_weight_ff <= WEIGHT_INIT;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seed_ff        <= seed_in;
         a_valid_ff     <= a_valid_in;
         b_valid_ff     <= b_valid_in;
         c_valid_ff     <= c_valid_in;
         found_ff       <= found_in;
         win_seed_ff    <= win_seed_in;
         best_weight_ff <= best_weight_in;
         strobe_ff      <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      keep_mask_ff <= keep_mask_in;
      tail_mask_ff <= tail_mask_in;
      a_seed_ff    <= a_seed_in;
      a_word_ff    <= a_word_in;
      b_seed_ff    <= b_seed_in;
      b_cnt_ff     <= b_cnt_in;
      c_seed_ff    <= c_seed_in;
      c_weight_ff  <= c_weight_in;
      rsp_ff       <= rsp_in;
   end

   assign strobe   = strobe_ff;
   assign rsp_data = rsp_ff;

endmodule
